[design/complex_arithmetic_unit_top_assert.svh]
// Assertion macros for the complex arithmetic unit checker.
// Expects clk and rst to be visible where the macros are used.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define CAU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("complex unit check failed");

// expression must never hold
`define CAU_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("complex unit check failed");

`endif

[design/cau_pkg.sv]
// Shared types, constants and saturation helpers for the complex arithmetic unit.
// No dependencies.
`default_nettype none
package cau_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int UNIT_STEPS    = 32;
  // accept edge to the edge that takes the result
  localparam int LATENCY       = UNIT_STEPS + 5;

  typedef enum logic [3:0] {
    KIND_ADD   = 4'd0,
    KIND_SUB   = 4'd1,
    KIND_MULT  = 4'd2,
    KIND_DIV   = 4'd3,
    KIND_CONJ  = 4'd4,
    KIND_SCALE = 4'd5,
    KIND_SDIV  = 4'd6,
    KIND_MOD   = 4'd7,
    KIND_MODSQ = 4'd8
  } kind_t;

  typedef struct packed {
    logic [3:0]         kind;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
    logic signed [31:0] factor;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_re;
    logic signed [31:0] out_im;
    logic               status;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [63:0] p0;
    logic signed [63:0] p1;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic signed [63:0] p4;
    logic signed [63:0] p5;
  } prod_t;

  typedef struct packed {
    logic               ov;
    logic signed [31:0] val;
  } sat_t;

  function automatic sat_t sat_sum(input logic signed [32:0] s);
    sat_t r;
    r.ov  = 1'b0;
    r.val = s[31:0];
    if (s > 33'sd2147483647) begin
      r.ov  = 1'b1;
      r.val = 32'sh7FFF_FFFF;
    end else if (s < -33'sd2147483648) begin
      r.ov  = 1'b1;
      r.val = 32'sh8000_0000;
    end
    return r;
  endfunction

  function automatic sat_t sat_mag(input logic neg, input logic [64:0] mag);
    sat_t r;
    r.ov  = 1'b0;
    r.val = mag[31:0];
    if (!neg) begin
      if (mag > 65'h7FFF_FFFF) begin
        r.ov  = 1'b1;
        r.val = 32'sh7FFF_FFFF;
      end
    end else begin
      if (mag > 65'h8000_0000) begin
        r.ov  = 1'b1;
        r.val = 32'sh8000_0000;
      end else begin
        r.val = -mag[31:0];
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] x);
    return x[31] ? 32'(-x) : 32'(x);
  endfunction

endpackage
`default_nettype wire

[design/complex_arithmetic_unit_top.sv]
// Top level of the complex arithmetic unit: input register, multipliers,
// sum stage, divider and square-root pipelines, side delay line, output.
// Depends on cau_pkg, cau_mul, cau_div, cau_sqrt.
//
// Usage:
//   An item (kind, a, b, factor) is taken at a rising edge with start high
//   and busy low. busy is high only while rst is high and the cycle after.
//   Exactly one result per item appears on result for one cycle with done
//   high, in the order the items were taken; it must be captured then.
//   Timing: every kind takes equally long from its accept edge to the
//   edge that takes its result. The 32-stage divider and square-root
//   pipelines (one quotient or root bit per stage) set that time; all other
//   kinds ride a matching delay line.
//   One item per cycle unless busy; start may stay high indefinitely.
//   Reset drops every item in flight; no result is shown for them.
//   Division by zero gives status 1 with a zero result; saturated parts
//   set overflow.
`default_nettype none
module complex_arithmetic_unit_top import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item,
  output logic      done,
  output out_item_t result
);

  localparam logic [64:0] RND_MASK = (65'd1 << FRAC_BITS) - 65'd1;
  localparam logic [63:0] HALF64   = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [3:0]         kind;
    logic               err;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] factor;
    sat_t               sre;
    sat_t               sim;
  } stage2_t;

  typedef struct packed {
    logic [3:0]  kind;
    logic        err;
    logic        neg_re;
    logic        neg_im;
    logic [63:0] mag_re;
    logic [63:0] mag_im;
    logic [63:0] den;
    sat_t        sre;
    sat_t        sim;
  } stage3_t;

  typedef struct packed {
    logic [3:0] kind;
    logic       err;
    logic       neg_re;
    logic       neg_im;
    sat_t       re;
    sat_t       im;
  } side_t;

  logic     rst_q;
  logic     v1, v2, v3;
  in_item_t x1;
  prod_t    prod;
  stage2_t  s2, s2_next;
  stage3_t  s3, s3_next;
  side_t    side [0:UNIT_STEPS];
  logic     sv   [0:UNIT_STEPS];
  side_t    side_next;
  logic [32:0] quo_re, quo_im;
  logic [31:0] root;
  out_item_t   result_next;

  always_ff @(posedge clk) begin
    rst_q <= rst;
  end
  assign busy = rst | rst_q;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      sv[0] <= 1'b0;
      done  <= 1'b0;
    end else begin
      v1    <= start & ~busy;
      v2    <= v1;
      v3    <= v2;
      sv[0] <= v3;
      done  <= sv[UNIT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    x1 <= item;
  end

  cau_mul u_mul (
    .clk  (clk),
    .x    (x1),
    .prod (prod)
  );

  // stage 2: short ops and error detection
  always_comb begin
    s2_next.kind   = x1.kind;
    s2_next.a_re   = x1.a_re;
    s2_next.a_im   = x1.a_im;
    s2_next.factor = x1.factor;
    s2_next.err    = (x1.kind == KIND_DIV && x1.b_re == '0 && x1.b_im == '0) ||
                     (x1.kind == KIND_SDIV && x1.factor == '0);
    s2_next.sre    = '0;
    s2_next.sim    = '0;
    unique case (x1.kind)
      KIND_ADD: begin
        s2_next.sre = sat_sum(33'(x1.a_re) + 33'(x1.b_re));
        s2_next.sim = sat_sum(33'(x1.a_im) + 33'(x1.b_im));
      end
      KIND_SUB: begin
        s2_next.sre = sat_sum(33'(x1.a_re) - 33'(x1.b_re));
        s2_next.sim = sat_sum(33'(x1.a_im) - 33'(x1.b_im));
      end
      KIND_CONJ: begin
        s2_next.sre = sat_sum(33'(x1.a_re));
        s2_next.sim = sat_sum(-33'(x1.a_im));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    s2 <= s2_next;
  end

  // stage 3: product sums as sign and magnitude, divider operands
  always_comb begin
    logic [63:0] sum_re;
    logic [63:0] sum_im;
    sum_re = (s2.kind == KIND_MULT) ? 64'(prod.p0 - prod.p1) : 64'(prod.p0 + prod.p1);
    sum_im = (s2.kind == KIND_DIV)  ? 64'(prod.p2 - prod.p3) : 64'(prod.p2 + prod.p3);
    s3_next.kind = s2.kind;
    s3_next.err  = s2.err;
    s3_next.sre  = s2.sre;
    s3_next.sim  = s2.sim;
    if (s2.kind == KIND_SDIV) begin
      s3_next.neg_re = s2.a_re[31] ^ s2.factor[31];
      s3_next.neg_im = s2.a_im[31] ^ s2.factor[31];
      s3_next.mag_re = {32'd0, abs32(s2.a_re)};
      s3_next.mag_im = {32'd0, abs32(s2.a_im)};
      s3_next.den    = {32'd0, abs32(s2.factor)};
    end else begin
      s3_next.neg_re = sum_re > HALF64;
      s3_next.neg_im = sum_im > HALF64;
      s3_next.mag_re = s3_next.neg_re ? -sum_re : sum_re;
      s3_next.mag_im = s3_next.neg_im ? -sum_im : sum_im;
      s3_next.den    = 64'(prod.p4 + prod.p5);
    end
  end

  always_ff @(posedge clk) begin
    s3 <= s3_next;
  end

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk (clk),
    .num (s3.mag_re),
    .den (s3.den),
    .quo (quo_re)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk (clk),
    .num (s3.mag_im),
    .den (s3.den),
    .quo (quo_im)
  );

  cau_sqrt u_sqrt (
    .clk  (clk),
    .val  (s3.mag_re),
    .root (root)
  );

  // delay-line entry: floor shift and saturate product kinds, pass short-op results
  always_comb begin
    logic [64:0] rnd_re;
    logic [64:0] rnd_im;
    sat_t        pr;
    sat_t        pi;
    rnd_re = s3.neg_re ? {1'b0, s3.mag_re} + RND_MASK : {1'b0, s3.mag_re};
    rnd_im = s3.neg_im ? {1'b0, s3.mag_im} + RND_MASK : {1'b0, s3.mag_im};
    pr     = sat_mag(s3.neg_re, rnd_re >> FRAC_BITS);
    pi     = sat_mag(s3.neg_im, rnd_im >> FRAC_BITS);
    side_next.kind   = s3.kind;
    side_next.err    = s3.err;
    side_next.neg_re = s3.neg_re;
    side_next.neg_im = s3.neg_im;
    side_next.re     = '0;
    side_next.im     = '0;
    unique case (s3.kind)
      KIND_ADD, KIND_SUB, KIND_CONJ: begin
        side_next.re = s3.sre;
        side_next.im = s3.sim;
      end
      KIND_MULT, KIND_SCALE: begin
        side_next.re = pr;
        side_next.im = pi;
      end
      KIND_MODSQ: begin
        side_next.re = pr;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    side[0] <= side_next;
  end

  for (genvar k = 1; k <= UNIT_STEPS; k++) begin : g_dly
    always_ff @(posedge clk) begin
      side[k] <= side[k-1];
      if (rst) begin
        sv[k] <= 1'b0;
      end else begin
        sv[k] <= sv[k-1];
      end
    end
  end

  // output select
  always_comb begin
    sat_t re;
    sat_t im;
    re = side[UNIT_STEPS].re;
    im = side[UNIT_STEPS].im;
    result_next.status = 1'b0;
    unique case (side[UNIT_STEPS].kind)
      KIND_DIV, KIND_SDIV: begin
        if (side[UNIT_STEPS].err) begin
          re = '0;
          im = '0;
          result_next.status = 1'b1;
        end else begin
          re = sat_mag(side[UNIT_STEPS].neg_re, 65'(quo_re));
          im = sat_mag(side[UNIT_STEPS].neg_im, 65'(quo_im));
        end
      end
      KIND_MOD: begin
        re = sat_mag(1'b0, 65'(root));
        im = '0;
      end
      default: begin
      end
    endcase
    result_next.out_re   = re.val;
    result_next.out_im   = im.val;
    result_next.overflow = re.ov | im.ov;
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

endmodule
`default_nettype wire

[design/cau_mul.sv]
// Operand selection and the six registered 32x32 multipliers.
// Depends on cau_pkg.
`default_nettype none
module cau_mul import cau_pkg::*; (
  input  logic     clk,
  input  in_item_t x,
  output prod_t    prod
);

  logic signed [31:0] ox0, oy0, ox1, oy1, ox2, oy2, ox3, oy3;

  // re = m0 +/- m1, im = m2 +/- m3, m4 + m5 = |b|^2
  always_comb begin
    ox0 = '0; oy0 = '0; ox1 = '0; oy1 = '0;
    ox2 = '0; oy2 = '0; ox3 = '0; oy3 = '0;
    unique case (x.kind)
      KIND_MULT: begin
        ox0 = x.a_re; oy0 = x.b_re; ox1 = x.a_im; oy1 = x.b_im;
        ox2 = x.a_re; oy2 = x.b_im; ox3 = x.a_im; oy3 = x.b_re;
      end
      KIND_DIV: begin
        ox0 = x.a_re; oy0 = x.b_re; ox1 = x.a_im; oy1 = x.b_im;
        ox2 = x.a_im; oy2 = x.b_re; ox3 = x.a_re; oy3 = x.b_im;
      end
      KIND_SCALE: begin
        ox0 = x.a_re; oy0 = x.factor;
        ox2 = x.a_im; oy2 = x.factor;
      end
      KIND_MOD, KIND_MODSQ: begin
        ox0 = x.a_re; oy0 = x.a_re;
        ox1 = x.a_im; oy1 = x.a_im;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod.p0 <= ox0 * oy0;
    prod.p1 <= ox1 * oy1;
    prod.p2 <= ox2 * oy2;
    prod.p3 <= ox3 * oy3;
    prod.p4 <= x.b_re * x.b_re;
    prod.p5 <= x.b_im * x.b_im;
  end

endmodule
`default_nettype wire

[design/cau_div.sv]
// Pipelined restoring divider lane: floor(num * 2^FRAC_BITS / den), one
// quotient bit per stage, with a flag for quotients of 2^32 and above.
// Depends on cau_pkg.
`default_nettype none
module cau_div import cau_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [32:0] quo
);

  localparam int SH = 32 - FRAC_BITS;

  logic [63:0] rem  [0:UNIT_STEPS];
  logic [31:0] low  [0:UNIT_STEPS];
  logic [31:0] qacc [0:UNIT_STEPS];
  logic [63:0] dv   [0:UNIT_STEPS];
  logic        big  [0:UNIT_STEPS];
  logic [63:0] head;

  assign head = num >> SH;

  always_ff @(posedge clk) begin
    big[0]  <= head >= den;
    rem[0]  <= head;
    low[0]  <= 32'(num << FRAC_BITS);
    qacc[0] <= '0;
    dv[0]   <= den;
  end

  for (genvar k = 1; k <= UNIT_STEPS; k++) begin : g_step
    logic [64:0] trial;
    logic        ge;
    assign trial = {rem[k-1], low[k-1][31]};
    assign ge    = trial >= {1'b0, dv[k-1]};
    always_ff @(posedge clk) begin
      rem[k]  <= ge ? 64'(trial - {1'b0, dv[k-1]}) : trial[63:0];
      low[k]  <= {low[k-1][30:0], 1'b0};
      qacc[k] <= {qacc[k-1][30:0], ge};
      dv[k]   <= dv[k-1];
      big[k]  <= big[k-1];
    end
  end

  assign quo = big[UNIT_STEPS] ? {1'b1, 32'd0} : {1'b0, qacc[UNIT_STEPS]};

endmodule
`default_nettype wire

[design/cau_sqrt.sv]
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// Depends on cau_pkg.
`default_nettype none
module cau_sqrt import cau_pkg::*; (
  input  logic        clk,
  input  logic [63:0] val,
  output logic [31:0] root
);

  logic [63:0] v   [0:UNIT_STEPS];
  logic [63:0] res [0:UNIT_STEPS];

  always_ff @(posedge clk) begin
    v[0]   <= val;
    res[0] <= '0;
  end

  for (genvar k = 1; k <= UNIT_STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (64 - 2 * k);
    logic [64:0] sum;
    logic        ge;
    assign sum = {1'b0, res[k-1]} + {1'b0, BIT};
    assign ge  = {1'b0, v[k-1]} >= sum;
    always_ff @(posedge clk) begin
      v[k]   <= ge ? 64'({1'b0, v[k-1]} - sum) : v[k-1];
      res[k] <= ge ? (res[k-1] >> 1) + BIT : res[k-1] >> 1;
    end
  end

  assign root = res[UNIT_STEPS][31:0];

endmodule
`default_nettype wire

[design/cau_checker.sv]
// Port-level checker for the complex arithmetic unit, bound to the top level.
// Depends on cau_pkg and complex_arithmetic_unit_top_assert.svh.
`default_nettype none
`include "complex_arithmetic_unit_top_assert.svh"
module cau_checker import cau_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input in_item_t  item,
  input logic      done,
  input out_item_t result
);

  `CAU_ASSERT_IMP(a_done_has_item, done, $past(start && !busy, LATENCY))
  `CAU_ASSERT_NEVER(a_err_no_ovf, done && result.status && result.overflow)
  `CAU_ASSERT_IMP(a_err_zero, done && result.status, result.out_re == 0 && result.out_im == 0)
  `CAU_ASSERT_IMP(a_mod_real, done && $past(item.kind, LATENCY) == KIND_MOD, result.out_im == 0 && !result.out_re[31])

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
`default_nettype wire

[tb/tb_complex_arithmetic_unit_top.sv]
// Self-checking testbench for complex_arithmetic_unit_top: directed table, then random items;
// results checked vs. table values or in-bench fixed-point predictions. Depends on cau_pkg, RTL.
`default_nettype none
module tb_complex_arithmetic_unit_top;
  import cau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB        = 16;
  localparam int N_RANDOM  = 1350;
  localparam int MAX_CYCLE = 400000;

  logic      clk;
  logic      rst;
  logic      start;
  logic      busy;
  in_item_t  item;
  logic      done;
  out_item_t result;

  complex_arithmetic_unit_top #(.FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  out_item_t pending_q[$];
  int        errors = 0;
  int        cycles = 0;

  // saturate a sign/magnitude value to 32 bits
  function automatic logic [31:0] clamp(input logic neg, input logic [64:0] mag,
                                        inout logic ov);
    if (!neg) begin
      if (mag > 65'h7FFF_FFFF) begin
        ov = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return mag[31:0];
    end
    if (mag > 65'h8000_0000) begin
      ov = 1'b1;
      return 32'h8000_0000;
    end
    return 32'(-mag[31:0]);
  endfunction

  // floor((p1 + p2) / 2^FB), saturated; done in 66 bits so the sum is exact
  function automatic logic [31:0] prod_floor(input logic signed [65:0] s, inout logic ov);
    logic signed [65:0] sh;
    logic               neg;
    logic [65:0]        m;
    sh  = s >>> FB;
    neg = sh < 0;
    m   = neg ? 66'(-sh) : 66'(sh);
    if (m[65]) m = 66'h1_0000_0000_0000_0000;
    return clamp(neg, m[64:0], ov);
  endfunction

  function automatic logic [31:0] quot(input logic neg, input logic [64:0] num,
                                       input logic [64:0] den, inout logic ov);
    logic [128:0] q;
    logic [64:0]  m;
    q = ({64'd0, num} << FB) / {64'd0, den};
    m = (q > 129'h1_0000_0000) ? 65'h1_0000_0000 : q[64:0];
    return clamp(neg, m, ov);
  endfunction

  function automatic logic [31:0] root(input logic [64:0] v);
    logic [64:0] lo, hi, mid;
    lo = 0;
    hi = 65'h1_0000_0000;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= v) lo = mid;
      else hi = mid;
    end
    return lo[31:0];
  endfunction

  function automatic out_item_t predict_alu(input in_item_t x);
    out_item_t          r;
    logic               ov;
    logic signed [65:0] ar, ai, br, bi, f, s;
    logic [64:0]        den;
    ov = 1'b0;
    r  = '0;
    ar = x.a_re; ai = x.a_im; br = x.b_re; bi = x.b_im; f = x.factor;
    case (x.kind)
      KIND_ADD: begin
        s = ar + br; r.out_re = clamp(s < 0, s < 0 ? 65'(-s) : 65'(s), ov);
        s = ai + bi; r.out_im = clamp(s < 0, s < 0 ? 65'(-s) : 65'(s), ov);
      end
      KIND_SUB: begin
        s = ar - br; r.out_re = clamp(s < 0, s < 0 ? 65'(-s) : 65'(s), ov);
        s = ai - bi; r.out_im = clamp(s < 0, s < 0 ? 65'(-s) : 65'(s), ov);
      end
      KIND_MULT: begin
        r.out_re = prod_floor(ar * br - ai * bi, ov);
        r.out_im = prod_floor(ar * bi + ai * br, ov);
      end
      KIND_DIV: begin
        if (br == 0 && bi == 0) r.status = 1'b1;
        else begin
          den = 65'(br * br + bi * bi);
          s = ar * br + ai * bi;
          r.out_re = quot(s < 0, s < 0 ? 65'(-s) : 65'(s), den, ov);
          s = ai * br - ar * bi;
          r.out_im = quot(s < 0, s < 0 ? 65'(-s) : 65'(s), den, ov);
        end
      end
      KIND_CONJ: begin
        r.out_re = x.a_re;
        r.out_im = clamp(ai > 0, ai < 0 ? 65'(-ai) : 65'(ai), ov);
      end
      KIND_SCALE: begin
        r.out_re = prod_floor(ar * f, ov);
        r.out_im = prod_floor(ai * f, ov);
      end
      KIND_SDIV: begin
        if (f == 0) r.status = 1'b1;
        else begin
          den = f < 0 ? 65'(-f) : 65'(f);
          r.out_re = quot((ar < 0) != (f < 0), ar < 0 ? 65'(-ar) : 65'(ar), den, ov);
          r.out_im = quot((ai < 0) != (f < 0), ai < 0 ? 65'(-ai) : 65'(ai), den, ov);
        end
      end
      KIND_MOD: begin
        r.out_re = clamp(1'b0, {33'd0, root(65'(ar * ar + ai * ai))}, ov);
      end
      KIND_MODSQ: r.out_re = prod_floor(ar * ar + ai * ai, ov);
      default: ;
    endcase
    r.overflow = ov;
    return r;
  endfunction

  typedef struct {
    in_item_t  stim;
    logic      fixed;
    out_item_t want;
  } row_t;

  row_t rows[$];

  function automatic in_item_t mk(input logic [3:0] k, input logic [31:0] a0,
                                  input logic [31:0] a1, input logic [31:0] b0,
                                  input logic [31:0] b1, input logic [31:0] f);
    in_item_t x;
    x.kind = k; x.a_re = a0; x.a_im = a1; x.b_re = b0; x.b_im = b1; x.factor = f;
    return x;
  endfunction

  function automatic out_item_t mo(input logic [31:0] re, input logic [31:0] im,
                                   input logic st, input logic ov);
    out_item_t o;
    o.out_re = re; o.out_im = im; o.status = st; o.overflow = ov;
    return o;
  endfunction

  task automatic add_row(input in_item_t x, input logic fx, input out_item_t w);
    row_t r;
    r.stim = x; r.fixed = fx; r.want = w;
    rows.push_back(r);
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'(int'($urandom_range(0, 8)) - 4);
      3: return 32'(int'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_idle(input int n);
    repeat (n) @(posedge clk);
  endtask

  // send one item: hold start until accepted
  task automatic send(input in_item_t x);
    item  <= x;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic gap();
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) g = 0;
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLE) begin
        $display("status: fail");
        $finish;
      end
    end
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result %h", $time, result);
        errors <= errors + 1;
      end else begin
        out_item_t w;
        w = pending_q.pop_front();
        if (result.out_re !== w.out_re || result.out_im !== w.out_im ||
            result.status !== w.status || result.overflow !== w.overflow) begin
          $display("%0t mismatch expected %h actual %h", $time, w, result);
          errors <= errors + 1;
        end
      end
    end
  end

  initial begin
    in_item_t x;
    rst    = 1'b1;
    start  = 1'b0;
    item   = '0;
    add_row(mk(KIND_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'hFFFF_FFFF, 0), 1,
            mo(32'h7FFF_FFFF, 32'h8000_0000, 0, 1));
    add_row(mk(KIND_SUB, 32'h8000_0000, 0, 1, 0, 0), 1, mo(32'h8000_0000, 0, 0, 1));
    add_row(mk(KIND_MULT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0),
            0, '0);
    add_row(mk(KIND_MULT, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 0),
            0, '0);
    add_row(mk(KIND_DIV, 5, 6, 0, 0, 0), 1, mo(0, 0, 1, 0));
    add_row(mk(KIND_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0), 0, '0);
    add_row(mk(KIND_DIV, 32'h0003_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 0),
            0, '0);
    add_row(mk(KIND_CONJ, 7, 32'h8000_0000, 0, 0, 0), 1, mo(7, 32'h7FFF_FFFF, 0, 1));
    add_row(mk(KIND_CONJ, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0), 1,
            mo(32'h8000_0000, 32'h8000_0001, 0, 0));
    add_row(mk(KIND_SCALE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h8000_0000), 0, '0);
    add_row(mk(KIND_SCALE, 32'hFFFF_FFFF, 1, 0, 0, 1), 1, mo(32'hFFFF_FFFF, 0, 0, 0));
    add_row(mk(KIND_SDIV, 1, 2, 0, 0, 0), 1, mo(0, 0, 1, 0));
    add_row(mk(KIND_SDIV, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 1), 0, '0);
    add_row(mk(KIND_SDIV, 32'hFFFF_FFFD, 7, 0, 0, 32'hFFFE_0000), 0, '0);
    add_row(mk(KIND_MOD, 32'h8000_0000, 32'h8000_0000, 0, 0, 0), 0, '0);
    add_row(mk(KIND_MOD, 3, 4, 0, 0, 0), 1, mo(5, 0, 0, 0));
    add_row(mk(KIND_MODSQ, 32'h8000_0000, 32'h8000_0000, 0, 0, 0), 0, '0);
    add_row(mk(KIND_MODSQ, 32'h0002_0000, 0, 0, 0, 0), 0, '0);
    add_row(mk(4'd9, 1, 2, 3, 4, 5), 1, mo(0, 0, 0, 0));
    add_row(mk(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF), 1, mo(0, 0, 0, 0));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) begin
      pending_q.push_back(rows[i].fixed ? rows[i].want : predict_alu(rows[i].stim));
      send(rows[i].stim);
      gap();
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      x.kind   = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                              : 4'($urandom_range(0, 8));
      x.a_re   = rnd_val();
      x.a_im   = rnd_val();
      x.b_re   = ($urandom_range(0, 15) == 0) ? 32'd0 : rnd_val();
      x.b_im   = ($urandom_range(0, 15) == 0) ? 32'd0 : rnd_val();
      x.factor = ($urandom_range(0, 15) == 0) ? 32'd0 : rnd_val();
      pending_q.push_back(predict_alu(x));
      send(x);
      if (n == N_RANDOM / 2) begin
        // drain the pipe once mid-run
        start <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
      end else begin
        gap();
      end
    end
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    wait_idle(LATENCY + 10);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire

[complex_arithmetic_unit_top.f]
+incdir+design
design/cau_pkg.sv
design/cau_mul.sv
design/cau_div.sv
design/cau_sqrt.sv
design/complex_arithmetic_unit_top.sv
design/cau_checker.sv
tb/tb_complex_arithmetic_unit_top.sv
